FILE: design/cmv_pkg.sv
`default_nettype none
package cmv_pkg;

    localparam int SLOTS      = 16;
    localparam int VPS        = 4;
    localparam int VLEN       = 128;
    localparam int SLOT_W     = 4;
    localparam int VEC_W      = 2;
    localparam int ELEM_W     = 7;
    localparam int POS_W      = 8;
    localparam int USED_W     = 5;
    localparam int CNT_W      = 3;
    localparam int ADDR_W     = SLOT_W + VEC_W + ELEM_W;
    localparam int SQ_W       = 38;
    localparam int DOT_W      = 39;
    localparam int NORM_SHIFT = 22;
    localparam int RAD_W      = SQ_W + NORM_SHIFT;
    localparam int ROOT_W     = RAD_W / 2;
    localparam int DEN_W      = 2 * ROOT_W + 1;
    localparam int NUM_W      = DOT_W - 1;
    localparam int FRAC_STEPS = 37;
    localparam int SCORE_W    = 16;
    localparam int THR_W      = 15;

    localparam logic [DEN_W-1:0]   EPS_SCALED = DEN_W'(64'd281474977);
    localparam logic [SCORE_W-1:0] SCORE_MAX  = 16'h7FFF;
    localparam logic [THR_W-1:0]   THR_RESET  = 15'd19661;

    localparam logic [2:0] MODE_QUERY  = 3'd0;
    localparam logic [2:0] MODE_ENROLL = 3'd1;
    localparam logic [2:0] MODE_ADD    = 3'd2;
    localparam logic [2:0] MODE_DELETE = 3'd3;
    localparam logic [2:0] MODE_CLEAR  = 3'd4;

    localparam logic [2:0] STAT_DONE    = 3'd0;
    localparam logic [2:0] STAT_NOMATCH = 3'd1;
    localparam logic [2:0] STAT_FULL    = 3'd2;
    localparam logic [2:0] STAT_BADSLOT = 3'd3;
    localparam logic [2:0] STAT_NOKEY   = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE, S_QROOT, S_QWAIT, S_VSEL, S_WALK, S_DRAIN, S_SROOT, S_SWAIT,
        S_DEN, S_DIV, S_DWAIT, S_BEST, S_ENROLL, S_ADD, S_COPY, S_CDRAIN
    } t_state;

    typedef struct packed {
        logic              rd_en;
        logic              cp_en;
        logic [SLOT_W-1:0] slot;
        logic [VEC_W-1:0]  vec;
        logic [ELEM_W-1:0] elem;
        logic              acc_clr;
        logic              sqrt_start;
        logic              sqrt_sel_q;
        logic              qroot_ld;
        logic              den_ld;
        logic              div_start;
        logic              best_clr;
        logic              best_upd;
        logic              tbl_enroll;
        logic              tbl_add;
        logic              drop;
        logic              emit;
        logic              emit_query;
        logic [2:0]        status;
        logic [SLOT_W-1:0] res_slot;
    } t_cmd;

    typedef struct packed {
        logic              pipe_busy;
        logic              dot_pos;
        logic              sqrt_done;
        logic              div_done;
        logic              enr_full;
        logic [USED_W-1:0] enr_target;
        logic [CNT_W-1:0]  slot_cnt;
        logic [USED_W-1:0] used;
    } t_stat;

endpackage
`default_nettype wire

FILE: design/cmv_isqrt.sv
`default_nettype none
module cmv_isqrt (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [cmv_pkg::RAD_W-1:0]   i_radicand,
    output logic                             o_done,
    output logic [cmv_pkg::ROOT_W-1:0]       o_root
);
    logic [cmv_pkg::RAD_W-1:0]  r_rad;
    logic [cmv_pkg::ROOT_W+2:0] r_rem, n_rem_t, trial;
    logic [cmv_pkg::ROOT_W-1:0] r_root;
    logic [4:0]                 r_cnt;
    logic                       r_run, r_done;

    assign n_rem_t = {r_rem[cmv_pkg::ROOT_W:0], r_rad[cmv_pkg::RAD_W-1 -: 2]};
    assign trial   = {1'b0, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_run && !i_start && r_cnt == 5'(cmv_pkg::ROOT_W - 1);
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(cmv_pkg::ROOT_W - 1)) begin
                    r_run <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_run) begin
            r_rad <= {r_rad[cmv_pkg::RAD_W-3:0], 2'b00};
            if (n_rem_t >= trial) begin
                r_rem  <= n_rem_t - trial;
                r_root <= {r_root[cmv_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= n_rem_t;
                r_root <= {r_root[cmv_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule
`default_nettype wire

FILE: design/cmv_div.sv
`default_nettype none
module cmv_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [cmv_pkg::NUM_W-1:0]     i_num,
    input  wire logic [cmv_pkg::DEN_W-1:0]     i_den,
    output logic                               o_done,
    output logic [cmv_pkg::SCORE_W-1:0]        o_quot
);
    logic [cmv_pkg::DEN_W-1:0]   r_rem, r_den;
    logic [cmv_pkg::DEN_W:0]     rem2, den2;
    logic [cmv_pkg::SCORE_W-1:0] r_q;
    logic                        r_sat, r_run, r_done, ge;
    logic [5:0]                  r_cnt;

    assign rem2 = {r_rem, 1'b0};
    assign den2 = {1'b0, r_den};
    assign ge   = rem2 >= den2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_run && !i_start && r_cnt == 6'(cmv_pkg::FRAC_STEPS - 1);
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(cmv_pkg::FRAC_STEPS - 1)) begin
                    r_run <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= cmv_pkg::DEN_W'(i_num);
            r_den <= i_den;
            r_sat <= cmv_pkg::DEN_W'(i_num) >= i_den;
            r_q   <= '0;
        end else if (r_run) begin
            r_rem <= ge ? cmv_pkg::DEN_W'(rem2 - den2) : rem2[cmv_pkg::DEN_W-1:0];
            r_q   <= {r_q[cmv_pkg::SCORE_W-2:0], ge};
            r_sat <= r_sat | r_q[cmv_pkg::SCORE_W-2];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_sat ? cmv_pkg::SCORE_MAX : r_q;
endmodule
`default_nettype wire

FILE: design/cmv_dp.sv
`default_nettype none
module cmv_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_accept,
    input  wire logic [2:0]                        i_mode,
    input  wire logic signed [15:0]                i_element,
    input  wire logic [63:0]                       i_profile_key,
    input  wire logic                              i_cfg_we,
    input  wire logic [cmv_pkg::THR_W-1:0]         i_cfg_data,
    input  wire cmv_pkg::t_cmd                     i_cmd,
    output cmv_pkg::t_stat                         o_stat,
    output logic                                   o_valid,
    output logic [2:0]                             o_status,
    output logic [3:0]                             o_slot,
    output logic signed [15:0]                     o_score
);
    logic [cmv_pkg::THR_W-1:0]   r_thr;
    logic [15:0]                 r_stage [cmv_pkg::VLEN];
    logic [15:0]                 r_store [2**cmv_pkg::ADDR_W];
    logic [cmv_pkg::POS_W-1:0]   r_pos;
    logic [cmv_pkg::SQ_W-1:0]    r_qsq, r_ssq;
    logic [15:0]                 r_stage_q, r_sdata, qd;
    logic                        r_qmask, r_rv1, r_rv2, r_cv;
    logic [cmv_pkg::ADDR_W-1:0]  raddr, r_waddr;
    logic signed [31:0]          r_pd, r_ps, el_sq;
    logic signed [cmv_pkg::DOT_W-1:0] r_dot;
    logic [cmv_pkg::CNT_W-1:0]   r_cnt [cmv_pkg::SLOTS];
    logic [63:0]                 r_key [cmv_pkg::SLOTS];
    logic [cmv_pkg::SLOTS-1:0]   r_pres;
    logic [cmv_pkg::USED_W-1:0]  r_used, target;
    logic [cmv_pkg::SLOTS-1:0]   hit;
    logic                        found_free, stage_en, drop_now;
    logic [cmv_pkg::ROOT_W-1:0]  r_qroot, s_root;
    logic [cmv_pkg::DEN_W-1:0]   r_den;
    logic [cmv_pkg::RAD_W-1:0]   radicand;
    logic                        sqrt_done, div_done;
    logic [cmv_pkg::SCORE_W-1:0] quot, r_best;
    logic [3:0]                  r_best_slot;
    logic [63:0]                 r_pkey;
    logic                        r_valid;
    logic [2:0]                  r_status;
    logic [3:0]                  r_slot;
    logic [15:0]                 r_score;

    assign stage_en = i_accept && (i_mode <= cmv_pkg::MODE_ADD) &&
                      (r_pos < cmv_pkg::POS_W'(cmv_pkg::VLEN));
    assign drop_now = (i_accept && (i_mode == cmv_pkg::MODE_DELETE ||
                       i_mode == cmv_pkg::MODE_CLEAR)) || i_cmd.drop;
    assign el_sq    = i_element * i_element;
    assign raddr    = {i_cmd.slot, i_cmd.vec, i_cmd.elem};
    assign qd       = r_qmask ? r_stage_q : 16'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= cmv_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_data;
        end
    end

    // staging buffer, entries at or past the fill count read as zero
    always_ff @(posedge i_clk) begin
        if (stage_en) begin
            r_stage[r_pos[cmv_pkg::ELEM_W-1:0]] <= i_element;
        end
        r_stage_q <= r_stage[i_cmd.elem];
        r_qmask   <= {1'b0, i_cmd.elem} < r_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_qsq <= '0;
        end else if (drop_now) begin
            r_pos <= '0;
            r_qsq <= '0;
        end else if (stage_en) begin
            r_pos <= r_pos + 1'b1;
            r_qsq <= r_qsq + cmv_pkg::SQ_W'($unsigned(el_sq));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_sdata <= r_store[raddr];
        end
        if (r_cv) begin
            r_store[r_waddr] <= qd;
        end
        r_waddr <= raddr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv1 <= 1'b0;
            r_rv2 <= 1'b0;
            r_cv  <= 1'b0;
        end else begin
            r_rv1 <= i_cmd.rd_en;
            r_rv2 <= r_rv1;
            r_cv  <= i_cmd.cp_en;
        end
    end

    // multiply then accumulate
    always_ff @(posedge i_clk) begin
        r_pd <= $signed(qd) * $signed(r_sdata);
        r_ps <= $signed(r_sdata) * $signed(r_sdata);
        if (i_cmd.acc_clr) begin
            r_dot <= '0;
            r_ssq <= '0;
        end else if (r_rv2) begin
            r_dot <= r_dot + cmv_pkg::DOT_W'(r_pd);
            r_ssq <= r_ssq + cmv_pkg::SQ_W'($unsigned(r_ps));
        end
    end

    assign radicand = i_cmd.sqrt_sel_q ? {r_qsq, {cmv_pkg::NORM_SHIFT{1'b0}}}
                                       : {r_ssq, {cmv_pkg::NORM_SHIFT{1'b0}}};

    cmv_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.sqrt_start),
        .i_radicand (radicand),
        .o_done     (sqrt_done),
        .o_root     (s_root)
    );

    cmv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_dot[cmv_pkg::NUM_W-1:0]),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.qroot_ld) begin
            r_qroot <= s_root;
        end
        if (i_cmd.den_ld) begin
            r_den <= cmv_pkg::DEN_W'(r_qroot * s_root) + cmv_pkg::EPS_SCALED;
        end
        if (i_cmd.best_clr) begin
            r_best      <= '0;
            r_best_slot <= '0;
        end else if (i_cmd.best_upd && quot > r_best) begin
            r_best      <= quot;
            r_best_slot <= i_cmd.slot;
        end
        if (i_accept) begin
            r_pkey <= i_profile_key;
        end
    end

    always_comb begin
        target     = r_used;
        found_free = 1'b0;
        for (int i = cmv_pkg::SLOTS - 1; i >= 0; i--) begin
            if (cmv_pkg::USED_W'(i) < r_used && (r_cnt[i] == '0 || !r_pres[i])) begin
                target     = cmv_pkg::USED_W'(i);
                found_free = 1'b1;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < cmv_pkg::SLOTS; i++) begin
            hit[i] = cmv_pkg::USED_W'(i) < r_used && r_pres[i] && r_key[i] == i_profile_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_pres <= '0;
            for (int i = 0; i < cmv_pkg::SLOTS; i++) begin
                r_cnt[i] <= '0;
                r_key[i] <= '0;
            end
        end else if (i_accept && i_mode == cmv_pkg::MODE_DELETE) begin
            for (int i = 0; i < cmv_pkg::SLOTS; i++) begin
                if (hit[i]) begin
                    r_cnt[i]  <= '0;
                    r_key[i]  <= '0;
                    r_pres[i] <= 1'b0;
                end
            end
        end else if (i_accept && i_mode == cmv_pkg::MODE_CLEAR) begin
            r_used <= '0;
        end else if (i_cmd.tbl_enroll) begin
            r_cnt[target[cmv_pkg::SLOT_W-1:0]]  <= cmv_pkg::CNT_W'(1);
            r_key[target[cmv_pkg::SLOT_W-1:0]]  <= r_pkey;
            r_pres[target[cmv_pkg::SLOT_W-1:0]] <= 1'b1;
            if (!found_free) begin
                r_used <= r_used + 1'b1;
            end
        end else if (i_cmd.tbl_add) begin
            r_cnt[i_cmd.slot] <= r_cnt[i_cmd.slot] + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_accept && i_mode == cmv_pkg::MODE_DELETE) begin
            r_valid  <= 1'b1;
            r_status <= (hit != '0) ? cmv_pkg::STAT_DONE : cmv_pkg::STAT_NOKEY;
            r_slot   <= '0;
            r_score  <= '0;
        end else if (i_accept && i_mode == cmv_pkg::MODE_CLEAR) begin
            r_valid  <= 1'b1;
            r_status <= cmv_pkg::STAT_DONE;
            r_slot   <= '0;
            r_score  <= '0;
        end else if (i_cmd.emit_query) begin
            r_valid <= 1'b1;
            r_score <= r_best;
            if (r_best > {1'b0, r_thr}) begin
                r_status <= cmv_pkg::STAT_DONE;
                r_slot   <= r_best_slot;
            end else begin
                r_status <= cmv_pkg::STAT_NOMATCH;
                r_slot   <= '0;
            end
        end else if (i_cmd.emit) begin
            r_valid  <= 1'b1;
            r_status <= i_cmd.status;
            r_slot   <= i_cmd.res_slot;
            r_score  <= '0;
        end else begin
            r_valid <= 1'b0;
        end
    end

    always_comb begin
        o_stat.pipe_busy  = r_rv1 | r_rv2;
        o_stat.dot_pos    = !r_dot[cmv_pkg::DOT_W-1] && r_dot != '0;
        o_stat.sqrt_done  = sqrt_done;
        o_stat.div_done   = div_done;
        o_stat.enr_full   = !found_free && r_used >= cmv_pkg::USED_W'(cmv_pkg::SLOTS);
        o_stat.enr_target = target;
        o_stat.slot_cnt   = r_cnt[i_cmd.slot];
        o_stat.used       = r_used;
    end

    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_slot   = r_slot;
    assign o_score  = r_score;
endmodule
`default_nettype wire

FILE: design/cmv_ctrl.sv
`default_nettype none
module cmv_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_accept,
    input  wire logic [2:0]     i_mode,
    input  wire logic           i_last_element,
    input  wire logic [3:0]     i_slot_number,
    input  wire cmv_pkg::t_stat i_stat,
    output cmv_pkg::t_cmd       o_cmd,
    output logic                o_busy
);
    cmv_pkg::t_state                r_state, n_state;
    logic [cmv_pkg::USED_W-1:0]     r_slot, n_slot;
    logic [cmv_pkg::CNT_W-1:0]      r_vec, n_vec;
    logic [cmv_pkg::ELEM_W-1:0]     r_elem, n_elem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cmv_pkg::S_IDLE;
            r_slot  <= '0;
            r_vec   <= '0;
            r_elem  <= '0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
            r_vec   <= n_vec;
            r_elem  <= n_elem;
        end
    end

    always_comb begin
        n_state = r_state;
        n_slot  = r_slot;
        n_vec   = r_vec;
        n_elem  = r_elem;
        o_cmd   = '0;
        o_cmd.slot = r_slot[cmv_pkg::SLOT_W-1:0];
        o_cmd.vec  = r_vec[cmv_pkg::VEC_W-1:0];
        o_cmd.elem = r_elem;
        case (r_state)
            cmv_pkg::S_IDLE: begin
                if (i_accept && i_last_element) begin
                    case (i_mode)
                        cmv_pkg::MODE_QUERY:  n_state = cmv_pkg::S_QROOT;
                        cmv_pkg::MODE_ENROLL: n_state = cmv_pkg::S_ENROLL;
                        cmv_pkg::MODE_ADD: begin
                            n_slot  = {1'b0, i_slot_number};
                            n_state = cmv_pkg::S_ADD;
                        end
                        default: n_state = cmv_pkg::S_IDLE;
                    endcase
                end
            end
            cmv_pkg::S_QROOT: begin
                o_cmd.sqrt_start = 1'b1;
                o_cmd.sqrt_sel_q = 1'b1;
                o_cmd.best_clr   = 1'b1;
                n_slot  = '0;
                n_vec   = '0;
                n_state = cmv_pkg::S_QWAIT;
            end
            cmv_pkg::S_QWAIT: begin
                if (i_stat.sqrt_done) begin
                    o_cmd.qroot_ld = 1'b1;
                    n_state = cmv_pkg::S_VSEL;
                end
            end
            cmv_pkg::S_VSEL: begin
                if (r_slot >= i_stat.used) begin
                    o_cmd.emit_query = 1'b1;
                    o_cmd.drop       = 1'b1;
                    n_state = cmv_pkg::S_IDLE;
                end else if (r_vec < i_stat.slot_cnt) begin
                    o_cmd.acc_clr = 1'b1;
                    n_elem  = '0;
                    n_state = cmv_pkg::S_WALK;
                end else begin
                    n_slot = r_slot + 1'b1;
                    n_vec  = '0;
                end
            end
            cmv_pkg::S_WALK: begin
                o_cmd.rd_en = 1'b1;
                n_elem = r_elem + 1'b1;
                if (r_elem == cmv_pkg::ELEM_W'(cmv_pkg::VLEN - 1)) begin
                    n_state = cmv_pkg::S_DRAIN;
                end
            end
            cmv_pkg::S_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    if (i_stat.dot_pos) begin
                        n_state = cmv_pkg::S_SROOT;
                    end else begin
                        n_vec   = r_vec + 1'b1;
                        n_state = cmv_pkg::S_VSEL;
                    end
                end
            end
            cmv_pkg::S_SROOT: begin
                o_cmd.sqrt_start = 1'b1;
                n_state = cmv_pkg::S_SWAIT;
            end
            cmv_pkg::S_SWAIT: begin
                if (i_stat.sqrt_done) begin
                    n_state = cmv_pkg::S_DEN;
                end
            end
            cmv_pkg::S_DEN: begin
                o_cmd.den_ld = 1'b1;
                n_state = cmv_pkg::S_DIV;
            end
            cmv_pkg::S_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state = cmv_pkg::S_DWAIT;
            end
            cmv_pkg::S_DWAIT: begin
                if (i_stat.div_done) begin
                    n_state = cmv_pkg::S_BEST;
                end
            end
            cmv_pkg::S_BEST: begin
                o_cmd.best_upd = 1'b1;
                n_vec   = r_vec + 1'b1;
                n_state = cmv_pkg::S_VSEL;
            end
            cmv_pkg::S_ENROLL: begin
                if (i_stat.enr_full) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = cmv_pkg::STAT_FULL;
                    o_cmd.drop   = 1'b1;
                    n_state = cmv_pkg::S_IDLE;
                end else begin
                    o_cmd.tbl_enroll = 1'b1;
                    n_slot  = i_stat.enr_target;
                    n_vec   = '0;
                    n_elem  = '0;
                    n_state = cmv_pkg::S_COPY;
                end
            end
            cmv_pkg::S_ADD: begin
                if (r_slot >= i_stat.used ||
                    i_stat.slot_cnt >= cmv_pkg::CNT_W'(cmv_pkg::VPS)) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = cmv_pkg::STAT_BADSLOT;
                    o_cmd.drop   = 1'b1;
                    n_state = cmv_pkg::S_IDLE;
                end else begin
                    o_cmd.tbl_add = 1'b1;
                    n_vec   = i_stat.slot_cnt;
                    n_elem  = '0;
                    n_state = cmv_pkg::S_COPY;
                end
            end
            cmv_pkg::S_COPY: begin
                o_cmd.cp_en = 1'b1;
                n_elem = r_elem + 1'b1;
                if (r_elem == cmv_pkg::ELEM_W'(cmv_pkg::VLEN - 1)) begin
                    n_state = cmv_pkg::S_CDRAIN;
                end
            end
            cmv_pkg::S_CDRAIN: begin
                o_cmd.emit     = 1'b1;
                o_cmd.status   = cmv_pkg::STAT_DONE;
                o_cmd.res_slot = r_slot[cmv_pkg::SLOT_W-1:0];
                o_cmd.drop     = 1'b1;
                n_state = cmv_pkg::S_IDLE;
            end
            default: n_state = cmv_pkg::S_IDLE;
        endcase
    end

    assign o_busy = r_state != cmv_pkg::S_IDLE;
endmodule
`default_nettype wire

FILE: design/cosine_match_vector_table_unit.sv
// element items that do not complete a vector, delete and clear leave the unit idle; the result
//   (delete, clear) comes the cycle after; a completed enroll or add copies 128 entries
// query: square root of the query energy, then per stored vector a walk of 128 elements,
//   plus a square root and a division when the dot product is positive; items never overlap
// the result strobe lasts one cycle and cannot be stalled
// synchronous active-low reset clears the slot table, fill count and threshold to 19661
`default_nettype none
module cosine_match_vector_table_unit (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [2:0]          i_mode,
    input  wire logic signed [15:0]  i_element,
    input  wire logic                i_last_element,
    input  wire logic [3:0]          i_slot_number,
    input  wire logic [63:0]         i_profile_key,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [14:0]         i_cfg_data,
    output logic                     o_valid,
    output logic [2:0]               o_status,
    output logic [3:0]               o_slot,
    output logic signed [15:0]       o_score
);
    cmv_pkg::t_cmd  cmd;
    cmv_pkg::t_stat stat;
    logic           accept, ctrl_busy;

    assign accept      = start && !ctrl_busy;
    assign busy        = ctrl_busy;
    assign o_cfg_ready = 1'b1;

    cmv_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_mode         (i_mode),
        .i_last_element (i_last_element),
        .i_slot_number  (i_slot_number),
        .i_stat         (stat),
        .o_cmd          (cmd),
        .o_busy         (ctrl_busy)
    );

    cmv_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_mode        (i_mode),
        .i_element     (i_element),
        .i_profile_key (i_profile_key),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_slot        (o_slot),
        .o_score       (o_score)
    );
endmodule
`default_nettype wire

FILE: tb/cosine_match_vector_table_unit_test.sv
`timescale 1ns / 1ps
`default_nettype none
module cosine_match_vector_table_unit_test;

    localparam int CYCLE_LIMIT = 6000000;

    typedef struct {
        logic [2:0]         status;
        logic [3:0]         slot;
        logic signed [15:0] score;
    } t_match_result;

    class t_match_table_scoreboard;
        shortint            store[cmv_pkg::SLOTS][cmv_pkg::VPS][cmv_pkg::VLEN];
        int unsigned        counts[cmv_pkg::SLOTS];
        logic [63:0]        keys[cmv_pkg::SLOTS];
        bit                 present[cmv_pkg::SLOTS];
        int unsigned        used;
        shortint            staging[cmv_pkg::VLEN];
        int unsigned        pos;
        int unsigned        threshold;
        t_match_result      pending_results[$];
        int                 errors;

        function new();
            foreach (counts[i]) begin
                counts[i] = 0;
                keys[i] = '0;
                present[i] = 0;
            end
            used = 0;
            threshold = 32'(cmv_pkg::THR_RESET);
            errors = 0;
            drop_staging();
        endfunction

        function void drop_staging();
            foreach (staging[i]) staging[i] = 0;
            pos = 0;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned root;
            longint unsigned b;
            root = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= root + b) begin
                    v -= root + b;
                    root = (root >> 1) + b;
                end else begin
                    root >>= 1;
                end
                b >>= 2;
            end
            return root;
        endfunction

        function longint unsigned energy(shortint v[cmv_pkg::VLEN]);
            longint unsigned acc;
            int x;
            acc = 0;
            for (int i = 0; i < cmv_pkg::VLEN; i++) begin
                x = v[i];
                acc += longint'(x * x);
            end
            return acc;
        endfunction

        function int unsigned cosine_score(longint unsigned q_root,
                                           shortint s[cmv_pkg::VLEN]);
            longint dot;
            longint unsigned den;
            longint unsigned rem;
            longint unsigned quot;
            dot = 0;
            for (int i = 0; i < cmv_pkg::VLEN; i++)
                dot += longint'(int'(staging[i]) * int'(s[i]));
            if (dot <= 0) return 0;
            den = q_root * int_sqrt(energy(s) << cmv_pkg::NORM_SHIFT) + 64'd281474977;
            if ($unsigned(dot) / den != 0) return cmv_pkg::SCORE_MAX;
            rem = $unsigned(dot) % den;
            quot = 0;
            for (int k = 0; k < cmv_pkg::FRAC_STEPS; k++) begin
                rem <<= 1;
                quot <<= 1;
                if (rem >= den) begin
                    rem -= den;
                    quot |= 1;
                end
                if (quot > cmv_pkg::SCORE_MAX) return cmv_pkg::SCORE_MAX;
            end
            return int'(quot);
        endfunction

        function void push(logic [2:0] st, int unsigned sl, int unsigned sc);
            t_match_result r;
            r.status = st;
            r.slot = sl[3:0];
            r.score = sc[15:0];
            pending_results.push_back(r);
        endfunction

        function void note_item(logic [2:0] mode, logic signed [15:0] element, logic last,
                                logic [3:0] slot_number, logic [63:0] key);
            bit found;
            int unsigned target;
            int unsigned best;
            int unsigned best_slot;
            int unsigned s;
            int unsigned n;
            longint unsigned q_root;
            if (mode > cmv_pkg::MODE_CLEAR) return;
            if (mode == cmv_pkg::MODE_DELETE) begin
                found = 0;
                drop_staging();
                for (int i = 0; i < used; i++) begin
                    if (present[i] && keys[i] == key) begin
                        counts[i] = 0;
                        present[i] = 0;
                        keys[i] = '0;
                        found = 1;
                    end
                end
                push(found ? cmv_pkg::STAT_DONE : cmv_pkg::STAT_NOKEY, 0, 0);
                return;
            end
            if (mode == cmv_pkg::MODE_CLEAR) begin
                drop_staging();
                used = 0;
                push(cmv_pkg::STAT_DONE, 0, 0);
                return;
            end
            if (pos < cmv_pkg::VLEN) begin
                staging[pos] = element;
                pos++;
            end
            if (!last) return;
            if (mode == cmv_pkg::MODE_QUERY) begin
                q_root = int_sqrt(energy(staging) << cmv_pkg::NORM_SHIFT);
                best = 0;
                best_slot = 0;
                for (int i = 0; i < used; i++) begin
                    n = counts[i] > cmv_pkg::VPS ? cmv_pkg::VPS : counts[i];
                    for (int j = 0; j < n; j++) begin
                        s = cosine_score(q_root, store[i][j]);
                        if (s > best) begin
                            best = s;
                            best_slot = i;
                        end
                    end
                end
                if (best > threshold) push(cmv_pkg::STAT_DONE, best_slot, best);
                else push(cmv_pkg::STAT_NOMATCH, 0, best);
            end else if (mode == cmv_pkg::MODE_ENROLL) begin
                target = used;
                for (int i = 0; i < used; i++) begin
                    if (counts[i] == 0 || !present[i]) begin
                        target = i;
                        break;
                    end
                end
                if (target == used && used >= cmv_pkg::SLOTS) begin
                    push(cmv_pkg::STAT_FULL, 0, 0);
                end else begin
                    if (target == used) used++;
                    counts[target] = 1;
                    keys[target] = key;
                    present[target] = 1;
                    store[target][0] = staging;
                    push(cmv_pkg::STAT_DONE, target, 0);
                end
            end else begin
                if (slot_number >= used || counts[slot_number] >= cmv_pkg::VPS) begin
                    push(cmv_pkg::STAT_BADSLOT, 0, 0);
                end else begin
                    store[slot_number][counts[slot_number]] = staging;
                    counts[slot_number]++;
                    push(cmv_pkg::STAT_DONE, 32'(slot_number), 0);
                end
            end
            drop_staging();
        endfunction

        function void check_result(logic [2:0] st, logic [3:0] sl, logic signed [15:0] sc);
            t_match_result e;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result status %0d slot %0d score %0d",
                         $time, st, sl, sc);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            if (st !== e.status) begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, st);
                errors++;
            end
            if (sl !== e.slot) begin
                $display("%0t: slot expected %0d actual %0d", $time, e.slot, sl);
                errors++;
            end
            if (sc !== e.score) begin
                $display("%0t: score expected %0d actual %0d", $time, e.score, sc);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               start = 0;
    logic               busy;
    logic [2:0]         i_mode = '0;
    logic signed [15:0] i_element = '0;
    logic               i_last_element = 0;
    logic [3:0]         i_slot_number = '0;
    logic [63:0]        i_profile_key = '0;
    logic               i_cfg_valid = 0;
    logic               o_cfg_ready;
    logic [14:0]        i_cfg_data = '0;
    logic               o_valid;
    logic [2:0]         o_status;
    logic [3:0]         o_slot;
    logic signed [15:0] o_score;

    t_match_table_scoreboard sb = new();
    int                 cycles = 0;
    int                 items_sent = 0;
    bit                 idling = 1;
    logic signed [15:0] kept[cmv_pkg::VLEN];
    logic [63:0]        key_pool[3];

    cosine_match_vector_table_unit DUT (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("cosine_match_vector_table_unit_test: done, errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_result(o_status, o_slot, o_score);
    end

    task automatic send_item(logic [2:0] mode, logic signed [15:0] element, logic last,
                             logic [3:0] slot_number, logic [63:0] key);
        if (idling && $urandom_range(0, 5) == 0) begin
            start <= 0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        start <= 1;
        i_mode <= mode;
        i_element <= element;
        i_last_element <= last;
        i_slot_number <= slot_number;
        i_profile_key <= key;
        do @(posedge i_clk); while (busy);
        sb.note_item(mode, element, last, slot_number, key);
        if (mode <= cmv_pkg::MODE_CLEAR) items_sent++;
    endtask

    task automatic settle();
        start <= 0;
        do @(posedge i_clk); while (sb.pending_results.size() != 0 || busy);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [14:0] value);
        i_cfg_valid <= 1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        sb.threshold = 32'(value);
    endtask

    function automatic logic [63:0] pick_key();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            5: return {$urandom, $urandom};
            default: return key_pool[$urandom_range(0, 2)];
        endcase
    endfunction

    task automatic stream_vector(logic [2:0] fmode, int len, bit reuse, bit mixed);
        int                 scale;
        logic signed [15:0] e;
        logic [2:0]         m;
        logic [3:0]         sn;
        logic [63:0]        key;
        scale = $urandom_range(0, 3);
        key = pick_key();
        if (sb.used > 0 && $urandom_range(0, 3) != 0) sn = 4'($urandom_range(0, sb.used - 1));
        else sn = 4'($urandom_range(0, 15));
        for (int i = 0; i < len; i++) begin
            case (scale)
                0: e = 16'($urandom);
                1: e = $signed(16'($urandom_range(0, 400))) - 16'sd200;
                2: e = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                default: e = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'sd0;
            endcase
            if (reuse && i < cmv_pkg::VLEN)
                e = kept[i] + $signed(16'($urandom_range(0, 15))) - 16'sd7;
            if (fmode != cmv_pkg::MODE_QUERY && i < cmv_pkg::VLEN) kept[i] = e;
            m = (i == len - 1 || !mixed) ? fmode : 3'($urandom_range(0, 2));
            send_item(m, e, i == len - 1, sn, key);
        end
    endtask

    task automatic random_phase(int count);
        int r;
        int stop;
        stop = items_sent + count;
        while (items_sent < stop) begin
            r = $urandom_range(0, 99);
            if (r < 30) stream_vector(cmv_pkg::MODE_QUERY, $urandom_range(1, 6),
                                      1'($urandom_range(0, 1)), $urandom_range(0, 4) == 0);
            else if (r < 55) stream_vector(cmv_pkg::MODE_ENROLL, $urandom_range(1, 6),
                                           $urandom_range(0, 3) == 0, $urandom_range(0, 4) == 0);
            else if (r < 80) stream_vector(cmv_pkg::MODE_ADD, $urandom_range(1, 6),
                                           1'($urandom_range(0, 1)), $urandom_range(0, 4) == 0);
            else if (r < 88) send_item(cmv_pkg::MODE_DELETE, 16'($urandom), 1'($urandom),
                                       4'($urandom), pick_key());
            else if (r < 90) send_item(cmv_pkg::MODE_CLEAR, 16'($urandom), 1'($urandom),
                                       4'($urandom), 64'($urandom));
            else if (r < 95) send_item(3'($urandom_range(5, 7)), 16'($urandom), 1'($urandom),
                                       4'($urandom), {$urandom, $urandom});
            else stream_vector(3'($urandom_range(0, 2)), $urandom_range(128, 131),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
        foreach (kept[i]) kept[i] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        write_threshold(cmv_pkg::THR_RESET);

        // empty table corner cases
        send_item(cmv_pkg::MODE_DELETE, 16'sd0, 1, 4'd0, '1);
        send_item(cmv_pkg::MODE_CLEAR, 16'sd0, 1, 4'd0, '0);
        send_item(cmv_pkg::MODE_QUERY, 16'sh7FFF, 1, 4'd0, '0);
        send_item(cmv_pkg::MODE_ADD, 16'sh8000, 1, 4'd0, '0);
        // enroll with extremes, then a vector whose mode changes mid-stream
        send_item(cmv_pkg::MODE_ENROLL, 16'sh7FFF, 0, 4'd15, '1);
        send_item(cmv_pkg::MODE_ENROLL, 16'sh8000, 1, 4'd15, '1);
        send_item(cmv_pkg::MODE_QUERY, 16'sd100, 0, 4'd0, '0);
        send_item(cmv_pkg::MODE_ENROLL, 16'sd300, 1, 4'd0, '0);
        send_item(3'd5, 16'sd1, 1, 4'd0, '0);
        send_item(3'd7, 16'sd1, 1, 4'd0, '0);
        send_item(cmv_pkg::MODE_QUERY, 16'sh7FFF, 0, 4'd0, '0);
        send_item(cmv_pkg::MODE_QUERY, 16'sh8000, 1, 4'd0, '0);
        send_item(cmv_pkg::MODE_QUERY, -16'sd5, 1, 4'd0, '0);
        for (int i = 0; i < 4; i++)
            send_item(cmv_pkg::MODE_ADD, 16'(i * 1000 + 1), 1, 4'd1, '0);
        send_item(cmv_pkg::MODE_ADD, 16'sd1, 1, 4'd2, '0);
        send_item(cmv_pkg::MODE_DELETE, 16'sd0, 1, 4'd0, '1);
        send_item(cmv_pkg::MODE_DELETE, 16'sd0, 1, 4'd0, '1);
        send_item(cmv_pkg::MODE_ENROLL, 16'sd77, 1, 4'd0, 64'h0123_4567_89AB_CDEF);
        send_item(cmv_pkg::MODE_CLEAR, 16'sd0, 1, 4'd0, '0);
        send_item(cmv_pkg::MODE_ADD, 16'sd1, 1, 4'd0, '0);

        settle();
        write_threshold(15'd0);
        random_phase(260);
        settle();
        write_threshold(15'h7FFF);
        random_phase(260);
        settle();
        write_threshold(15'($urandom_range(0, 32767)));
        random_phase(260);
        settle();
        write_threshold(cmv_pkg::THR_RESET);
        idling = 0;
        random_phase(260);

        start <= 0;
        do @(posedge i_clk); while (sb.pending_results.size() != 0);
        repeat (300) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("cosine_match_vector_table_unit_test: done, clean");
        end else begin
            $display("cosine_match_vector_table_unit_test: done, errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
